// ===== src/cic_pkg.sv =====
// Shared types and constants for the CIC decimator.
// No dependencies; every other file of the block depends on this package.
`default_nettype none

package cic_pkg;

    localparam int PHASE_WIDTH = 16;
    localparam int CNT_WIDTH   = $clog2(PHASE_WIDTH);
    localparam int OUT_WIDTH   = 32;
    localparam int NS_WIDTH    = 4;
    localparam int DD_WIDTH    = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [DD_WIDTH-1:0] DELAY_ONE = 2'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_STAGES = 2'd0,
        CFG_DIFF_DELAY = 2'd1,
        CFG_DECIM_RATE = 2'd2
    } cic_cfg_idx_t;

    typedef struct packed {
        logic valid;
        logic emit;
    } cic_tok_t;

    typedef struct packed {
        logic busy;
        logic emit;
    } cic_phase_t;

endpackage

`default_nettype wire

// ===== src/cic_if.sv =====
// Channel interfaces of the CIC decimator: input word, output word and
// configuration write channel. Depends on cic_pkg.
`default_nettype none

interface cic_in_if #(parameter int IN_WIDTH = 16) ();
    logic                       valid;
    logic                       ready;
    logic signed [IN_WIDTH-1:0] sample_in;
    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

interface cic_out_if ();
    logic                                valid;
    logic                                ready;
    logic signed [cic_pkg::OUT_WIDTH-1:0] sample_out;
    modport source (output valid, output sample_out, input ready);
    modport sink (input valid, input sample_out, output ready);
endinterface

interface cic_cfg_if ();
    logic                               valid;
    logic                               ready;
    logic [cic_pkg::CFG_IDX_W-1:0]      index;
    logic [cic_pkg::CFG_DATA_W-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/cic_decimator.sv =====
// Top level of the CIC decimator: configuration registers, phase counter,
// a row of integrator/comb cells and the output register.
// Depends on cic_pkg, cic_if.sv, cic_cell and cic_phase.
//
// Usage: input words arrive on din, decimated words leave on dout, and the
// registers num_stages (index 0), diff_delay (1) and decim_rate (2) are
// written on cfg, which is always ready. Writes must be made only while
// idle; the block does not enforce it. One input word is taken every clock
// while din.ready is high. The word goes up the integrator row one cell per
// cycle; on an emitting word the last active cell turns it into the comb row,
// which comes back down one cell per cycle while the row is not held; the
// finished word is then registered for dout. A write to decim_rate starts
// a remainder pass over the phase, during which din.ready is low.
// Reset clears all accumulators and histories, loads num_stages = 4,
// diff_delay = 1 and decim_rate = 8, and makes the first input word emit.
// When dout is stalled with a word waiting, the row keeps running until a
// second finished word reaches the end of the comb row; then the whole row
// and din.ready hold until dout.ready returns.
`default_nettype none

module cic_decimator #(
    parameter int MAX_STAGES = 8,
    parameter int ACC_WIDTH  = 32,
    parameter int IN_WIDTH   = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    cic_in_if.sink    din,
    cic_out_if.source dout,
    cic_cfg_if.sink   cfg
);
    import cic_pkg::*;

    localparam int NSE_WIDTH = $clog2(MAX_STAGES + 1);

    logic [NS_WIDTH-1:0]    num_stages_reg;
    logic [DD_WIDTH-1:0]    diff_delay_reg;
    logic [PHASE_WIDTH-1:0] decim_rate_reg;
    logic [NSE_WIDTH-1:0]   ns_eff;
    logic                   delay_one;
    logic                   cfg_wr;
    logic                   rate_wr;
    logic                   accept;
    logic                   en;
    cic_phase_t             ph;

    cic_tok_t               itok [MAX_STAGES+1];
    logic [ACC_WIDTH-1:0]   idata [MAX_STAGES+1];
    logic                   cvalid [MAX_STAGES+1];
    logic [ACC_WIDTH-1:0]   cdata [MAX_STAGES+1];
    logic [MAX_STAGES-1:0]  active_vec;
    logic [MAX_STAGES-1:0]  last_vec;

    logic                   out_valid_reg;
    logic [OUT_WIDTH-1:0]   out_data_reg;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;
    assign rate_wr   = cfg_wr && (cfg.index == CFG_DECIM_RATE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_stages_reg <= NS_WIDTH'(4);
            diff_delay_reg <= DELAY_ONE;
            decim_rate_reg <= PHASE_WIDTH'(8);
        end
        else if (cfg_wr)
        begin
            unique case (cfg.index)
                CFG_NUM_STAGES: num_stages_reg <= cfg.data[NS_WIDTH-1:0];
                CFG_DIFF_DELAY: diff_delay_reg <= cfg.data[DD_WIDTH-1:0];
                CFG_DECIM_RATE: decim_rate_reg <= cfg.data[PHASE_WIDTH-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        if (num_stages_reg == '0)
        begin
            ns_eff = NSE_WIDTH'(1);
        end
        else if (int'(num_stages_reg) > MAX_STAGES)
        begin
            ns_eff = NSE_WIDTH'(MAX_STAGES);
        end
        else
        begin
            ns_eff = NSE_WIDTH'(num_stages_reg);
        end
    end

    assign delay_one = (diff_delay_reg == DELAY_ONE);

    cic_phase u_phase (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rate_wr (rate_wr),
        .rate    (decim_rate_reg),
        .status  (ph)
    );

    assign en        = !(cvalid[0] && out_valid_reg && !dout.ready);
    assign din.ready = en && !ph.busy;
    assign accept    = din.valid && din.ready;

    assign itok[0].valid      = accept;
    assign itok[0].emit       = ph.emit;
    assign idata[0]           = ACC_WIDTH'($signed(din.sample_in[IN_WIDTH-1:0]));
    assign cvalid[MAX_STAGES] = 1'b0;
    assign cdata[MAX_STAGES]  = '0;

    for (genvar k = 0; k < MAX_STAGES; k++)
    begin : g_cell
        assign active_vec[k] = (NSE_WIDTH'(k) < ns_eff);
        assign last_vec[k]   = (NSE_WIDTH'(k + 1) == ns_eff);

        cic_cell #(
            .ACC_WIDTH (ACC_WIDTH)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .en             (en),
            .active         (active_vec[k]),
            .is_last        (last_vec[k]),
            .delay_one      (delay_one),
            .int_in_tok     (itok[k]),
            .int_in_data    (idata[k]),
            .int_out_tok    (itok[k+1]),
            .int_out_data   (idata[k+1]),
            .comb_in_valid  (cvalid[k+1]),
            .comb_in_data   (cdata[k+1]),
            .comb_out_valid (cvalid[k]),
            .comb_out_data  (cdata[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en && cvalid[0])
        begin
            out_valid_reg <= 1'b1;
        end
        else if (dout.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && cvalid[0])
        begin
            out_data_reg <= OUT_WIDTH'(cdata[0]);
        end
    end

    assign dout.valid      = out_valid_reg;
    assign dout.sample_out = out_data_reg;

    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        ph.busy |-> !din.ready)
        else $error("input accepted during phase renormalization");

    a_rate_write_starts_pass: assert property (@(posedge clk) disable iff (!rst_n)
        rate_wr |=> ph.busy)
        else $error("rate write did not start the remainder pass");

    a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cvalid[0] && !en) |=> cvalid[0])
        else $error("finished word lost while the output was stalled");

    a_one_turnaround_cell: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(last_vec))
        else $error("not exactly one cell turns the row around");

endmodule

`default_nettype wire

// ===== src/cic_cell.sv =====
// One stage of the filter: an integrator and its matching comb.
// Depends on cic_pkg for the token type.
`default_nettype none

module cic_cell #(
    parameter int ACC_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  active,
    input  wire logic                  is_last,
    input  wire logic                  delay_one,
    input  wire cic_pkg::cic_tok_t     int_in_tok,
    input  wire logic [ACC_WIDTH-1:0]  int_in_data,
    output cic_pkg::cic_tok_t          int_out_tok,
    output logic [ACC_WIDTH-1:0]       int_out_data,
    input  wire logic                  comb_in_valid,
    input  wire logic [ACC_WIDTH-1:0]  comb_in_data,
    output logic                       comb_out_valid,
    output logic [ACC_WIDTH-1:0]       comb_out_data
);
    import cic_pkg::*;

    logic [ACC_WIDTH-1:0] acc_reg;
    cic_tok_t             itok_reg;
    logic [ACC_WIDTH-1:0] hist1_reg;
    logic [ACC_WIDTH-1:0] hist2_reg;
    logic                 cvalid_reg;
    logic [ACC_WIDTH-1:0] cdata_reg;
    logic                 c_valid;
    logic [ACC_WIDTH-1:0] c_data;
    logic                 int_take;

    assign int_take = int_in_tok.valid && active;
    assign c_valid  = is_last ? (itok_reg.valid && itok_reg.emit) : comb_in_valid;
    assign c_data   = is_last ? acc_reg : comb_in_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            itok_reg   <= '0;
            hist1_reg  <= '0;
            hist2_reg  <= '0;
            cvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            itok_reg.valid <= int_take;
            itok_reg.emit  <= int_in_tok.emit;
            if (int_take)
            begin
                acc_reg <= acc_reg + int_in_data;
            end
            cvalid_reg <= c_valid && active;
            if (c_valid && active)
            begin
                hist1_reg <= c_data;
                hist2_reg <= hist1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && c_valid && active)
        begin
            cdata_reg <= c_data - (delay_one ? hist1_reg : hist2_reg);
        end
    end

    assign int_out_tok    = itok_reg;
    assign int_out_data   = acc_reg;
    assign comb_out_valid = cvalid_reg;
    assign comb_out_data  = cdata_reg;

endmodule

`default_nettype wire

// ===== src/cic_phase.sv =====
// Decimation phase counter with a bit-serial remainder unit that
// renormalizes the phase after the ratio is rewritten. Depends on cic_pkg.
`default_nettype none

module cic_phase (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            accept,
    input  wire logic                            rate_wr,
    input  wire logic [cic_pkg::PHASE_WIDTH-1:0] rate,
    output cic_pkg::cic_phase_t                  status
);
    import cic_pkg::*;

    logic [PHASE_WIDTH-1:0] rate_eff;
    logic [PHASE_WIDTH-1:0] phase_reg;
    logic [PHASE_WIDTH-1:0] pnext_reg;
    logic [PHASE_WIDTH-1:0] pnext_inc;
    logic                   busy_reg;
    logic [CNT_WIDTH-1:0]   cnt_reg;
    logic [PHASE_WIDTH-1:0] dvd_reg;
    logic [PHASE_WIDTH-1:0] rem_reg;
    logic [PHASE_WIDTH:0]   trial;
    logic [PHASE_WIDTH:0]   diff;
    logic [PHASE_WIDTH-1:0] rem_next;

    assign rate_eff  = (rate == '0) ? PHASE_WIDTH'(1) : rate;
    assign pnext_inc = pnext_reg + PHASE_WIDTH'(1);
    assign trial     = {rem_reg, dvd_reg[PHASE_WIDTH-1]};
    assign diff      = trial - {1'b0, rate_eff};
    assign rem_next  = (trial >= {1'b0, rate_eff}) ? diff[PHASE_WIDTH-1:0]
                                                   : trial[PHASE_WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '1;
            pnext_reg <= '0;
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
            dvd_reg   <= '0;
            rem_reg   <= '0;
        end
        else if (rate_wr)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            dvd_reg  <= phase_reg + PHASE_WIDTH'(1);
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_reg << 1;
            cnt_reg <= cnt_reg + CNT_WIDTH'(1);
            if (cnt_reg == CNT_WIDTH'(PHASE_WIDTH - 1))
            begin
                busy_reg  <= 1'b0;
                pnext_reg <= rem_next;
            end
        end
        else if (accept)
        begin
            phase_reg <= pnext_reg;
            pnext_reg <= (pnext_inc == rate_eff) ? '0 : pnext_inc;
        end
    end

    assign status.busy = busy_reg;
    assign status.emit = (pnext_reg == '0);

endmodule

`default_nettype wire
